FILE: rtl/falling_sand_grid_step_core_assert.svh
// Assertion macros shared by the grid step core.
`ifndef FALLING_SAND_GRID_STEP_CORE_ASSERT_SVH
`define FALLING_SAND_GRID_STEP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FSGS_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FSGS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSGS_ASSERT_CLK(label, clk, rst, prop, msg)
`define FSGS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/fsgs_pkg.sv
package fsgs_pkg;

   typedef logic [1:0] req_kind_field_type;
   typedef logic [7:0] cell_x_type;
   typedef logic [6:0] cell_y_type;
   typedef logic [1:0] material_type;
   typedef logic [7:0] rule_byte_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 64;
   localparam int RULE_REG_COUNT = 3;
   localparam int RULE_SLOTS = 8;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0] rule_reg_type;

   localparam csr_index_type CSR_RULES_WALL = 2'd0;
   localparam csr_index_type CSR_RULES_SAND = 2'd1;
   localparam csr_index_type CSR_RULES_SPARE = 2'd2;

   localparam rule_reg_type SAND_RULES_RESET = 64'h0000_0000_0051_7344;

   localparam material_type MAT_EMPTY = 2'd0;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_STEP  = 2'd2
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_CELL_RD,
      ST_CELL_EVAL,
      ST_RULE,
      ST_RULE_EVAL,
      ST_VACATE
   } state_type;

endpackage

FILE: rtl/fsgs_req_if.sv
interface fsgs_req_if;
   logic                             valid;
   logic                             ready;
   fsgs_pkg::req_kind_field_type     req_type;
   fsgs_pkg::cell_x_type             cell_x;
   fsgs_pkg::cell_y_type             cell_y;
   fsgs_pkg::material_type           write_material;

   modport source (output valid, output req_type, output cell_x, output cell_y,
                   output write_material, input ready);
   modport sink (input valid, input req_type, input cell_x, input cell_y,
                 input write_material, output ready);
endinterface

FILE: rtl/fsgs_rsp_if.sv
interface fsgs_rsp_if;
   logic                         valid;
   logic                         ready;
   fsgs_pkg::req_kind_field_type resp_type;
   fsgs_pkg::material_type       read_material;

   modport source (output valid, output resp_type, output read_material, input ready);
   modport sink (input valid, input resp_type, input read_material, output ready);
endinterface

FILE: rtl/fsgs_bank.sv
module fsgs_bank #(
   parameter int DEPTH = 32768,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [AW-1:0]          waddr,
   input  fsgs_pkg::material_type wdata,
   input  logic [AW-1:0]          raddr_a,
   input  logic [AW-1:0]          raddr_b,
   output fsgs_pkg::material_type rdata_a,
   output fsgs_pkg::material_type rdata_b
);

   fsgs_pkg::material_type mem [0:DEPTH-1];
   fsgs_pkg::material_type rdata_a_ff;
   fsgs_pkg::material_type rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

FILE: rtl/fsgs_rule_unit.sv
module fsgs_rule_unit #(
   parameter int GRID_WIDTH = 256,
   parameter int GRID_HEIGHT = 128,
   localparam int XW = $clog2(GRID_WIDTH),
   localparam int YW = $clog2(GRID_HEIGHT),
   localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
   input  logic [XW-1:0]           pos_x,
   input  logic [YW-1:0]           pos_y,
   input  logic [AW-1:0]           pos_addr,
   input  fsgs_pkg::rule_byte_type rule_byte,
   output logic                    chk_ok,
   output logic                    mov_ok,
   output logic [AW-1:0]           chk_addr,
   output logic [AW-1:0]           mov_addr
);

   // Offsets are 2-bit two's complement: dx in the low pair, dy in the high pair.
   function automatic logic [AW:0] locate(input logic [XW-1:0] px, input logic [YW-1:0] py,
                                          input logic [AW-1:0] pa, input logic [3:0] code);
      logic signed [XW+1:0] nx;
      logic signed [YW+1:0] ny;
      logic signed [AW+1:0] na;
      logic                 ok;
      nx = $signed({2'b00, px}) + (XW+2)'(signed'(code[1:0]));
      ny = $signed({2'b00, py}) + (YW+2)'(signed'(code[3:2]));
      ok = (nx >= 0) && (nx < (XW+2)'(GRID_WIDTH)) &&
           (ny >= 0) && (ny < (YW+2)'(GRID_HEIGHT));
      na = $signed({2'b00, pa}) + (AW+2)'(signed'(code[3:2])) * (AW+2)'(GRID_WIDTH)
           + (AW+2)'(signed'(code[1:0]));
      return {ok, na[AW-1:0]};
   endfunction

   logic [AW:0] chk_loc;
   logic [AW:0] mov_loc;

   assign chk_loc  = locate(pos_x, pos_y, pos_addr, rule_byte[3:0]);
   assign mov_loc  = locate(pos_x, pos_y, pos_addr, rule_byte[7:4]);
   assign chk_ok   = chk_loc[AW];
   assign mov_ok   = mov_loc[AW];
   assign chk_addr = chk_loc[AW-1:0];
   assign mov_addr = mov_loc[AW-1:0];

endmodule

FILE: rtl/falling_sand_grid_step_core.sv
// Falling-sand grid engine with a word-per-request interface.
// req_ch carries one request word: write a cell, read a cell or run one
// generation step. rsp_ch returns exactly one word per request, in order,
// echoing the request kind and carrying the read material (zero otherwise).
// csr_we/csr_index/csr_wdata load the three 64-bit rule registers; the user must
// write them only while idle, which the block does not enforce. The grid lives
// in two single-write, dual-read banks; one holds the current generation and the
// other is built up as the next one, then their roles swap. A write is answered
// from the result register; a read passes the bank's read register and ST_READ
// first. A step runs a copy sweep of the current bank into the next one, then a
// scan of every cell in which each particle tries its rules in turn, reading and
// checking each, and one that moves also vacates its cell. The step time is set
// by the single write port of the next-generation bank. After reset the current
// bank is swept to empty; req_ch is not ready meanwhile and configuration writes
// are taken as usual. The result register holds its word while rsp_ch.ready is
// low; a new request is accepted in the same cycle as the pending word is taken.
`include "falling_sand_grid_step_core_assert.svh"

module falling_sand_grid_step_core #(
   parameter int GRID_WIDTH = 256,
   parameter int GRID_HEIGHT = 128,
   parameter int RULES_PER_MATERIAL = 8,
   parameter int MATERIAL_COUNT = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   fsgs_req_if.sink                req_ch,
   fsgs_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  fsgs_pkg::csr_index_type csr_index,
   input  fsgs_pkg::rule_reg_type  csr_wdata
);

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int XW = $clog2(GRID_WIDTH);
   localparam int YW = $clog2(GRID_HEIGHT);
   localparam int AW = $clog2(CELLS);
   localparam int JW = (RULES_PER_MATERIAL > 1) ? $clog2(RULES_PER_MATERIAL) : 1;

   fsgs_pkg::state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [JW-1:0] j_ff, j_in;
   fsgs_pkg::material_type m_ff, m_in;
   fsgs_pkg::req_kind_field_type kind_ff, kind_in;
   logic rd_ok_ff, rd_ok_in;
   logic sel_ff, sel_in;
   logic cp_pend_ff, cp_pend_in;
   logic [AW-1:0] cp_addr_ff, cp_addr_in;
   logic rsp_valid_ff, rsp_valid_in;
   fsgs_pkg::req_kind_field_type rsp_type_ff, rsp_type_in;
   fsgs_pkg::material_type rsp_mat_ff, rsp_mat_in;
   fsgs_pkg::rule_reg_type rules_ff [0:fsgs_pkg::RULE_REG_COUNT-1];
   fsgs_pkg::rule_reg_type rules_in [0:fsgs_pkg::RULE_REG_COUNT-1];

   logic req_ready;
   logic req_fire;
   logic advance;
   logic last_cell;
   logic rq_inside;
   logic [AW-1:0] rq_addr;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic cur_we;
   logic [AW-1:0] cur_waddr;
   fsgs_pkg::material_type cur_wdata;
   logic scan_we;
   logic [AW-1:0] scan_waddr;
   fsgs_pkg::material_type scan_wdata;
   logic nxt_we;
   logic [AW-1:0] nxt_waddr;
   fsgs_pkg::material_type nxt_wdata;
   logic b0_we, b1_we;
   logic [AW-1:0] b0_waddr, b1_waddr;
   fsgs_pkg::material_type b0_wdata, b1_wdata;
   fsgs_pkg::material_type b0_rdata_a, b0_rdata_b, b1_rdata_a, b1_rdata_b;
   fsgs_pkg::material_type rdata_a, rdata_b;
   logic [1:0] mat_idx;
   fsgs_pkg::rule_byte_type rule_byte;
   logic chk_ok, mov_ok;
   logic [AW-1:0] chk_addr, mov_addr;

   function automatic logic mat_active(input fsgs_pkg::material_type m);
      return (m != fsgs_pkg::MAT_EMPTY) && (32'(m) < MATERIAL_COUNT);
   endfunction

   // Request decode.
   assign rq_inside = (32'(req_ch.cell_x) < GRID_WIDTH) && (32'(req_ch.cell_y) < GRID_HEIGHT);
   assign rq_addr = AW'(32'(req_ch.cell_y) * 32'(GRID_WIDTH) + 32'(req_ch.cell_x));
   assign req_fire = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;
   assign last_cell = (idx_ff == AW'(CELLS - 1));

   // Rule selection for the particle under the scan.
   assign mat_idx = m_ff - 2'd1;
   assign rule_byte = rules_ff[mat_idx][{3'(j_ff), 3'b000} +: 8];

   fsgs_rule_unit #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_rule (
      .pos_x     (x_ff),
      .pos_y     (y_ff),
      .pos_addr  (idx_ff),
      .rule_byte (rule_byte),
      .chk_ok    (chk_ok),
      .mov_ok    (mov_ok),
      .chk_addr  (chk_addr),
      .mov_addr  (mov_addr)
   );

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      x_in = x_ff;
      y_in = y_ff;
      j_in = j_ff;
      m_in = m_ff;
      kind_in = kind_ff;
      rd_ok_in = rd_ok_ff;
      sel_in = sel_ff;
      cp_pend_in = 1'b0;
      cp_addr_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_type_in = rsp_type_ff;
      rsp_mat_in = rsp_mat_ff;
      rd_addr_a = idx_ff;
      rd_addr_b = mov_addr;
      cur_we = 1'b0;
      cur_waddr = idx_ff;
      cur_wdata = fsgs_pkg::MAT_EMPTY;
      scan_we = 1'b0;
      scan_waddr = mov_addr;
      scan_wdata = m_ff;
      advance = 1'b0;
      req_ready = 1'b0;

      case (state_ff)
         fsgs_pkg::ST_CLEAR: begin
            cur_we = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (last_cell) begin
               idx_in = '0;
               state_in = fsgs_pkg::ST_IDLE;
            end
         end
         fsgs_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ch.ready;
            if (req_fire) begin
               kind_in = req_ch.req_type;
               rd_addr_a = rq_addr;
               rd_ok_in = rq_inside;
               case (req_ch.req_type)
                  fsgs_pkg::REQ_WRITE: begin
                     cur_we = rq_inside;
                     cur_waddr = rq_addr;
                     cur_wdata = req_ch.write_material;
                     rsp_valid_in = 1'b1;
                     rsp_type_in = req_ch.req_type;
                     rsp_mat_in = fsgs_pkg::MAT_EMPTY;
                  end
                  fsgs_pkg::REQ_READ: begin
                     state_in = fsgs_pkg::ST_READ;
                  end
                  fsgs_pkg::REQ_STEP: begin
                     idx_in = '0;
                     state_in = fsgs_pkg::ST_COPY;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_type_in = req_ch.req_type;
                     rsp_mat_in = fsgs_pkg::MAT_EMPTY;
                  end
               endcase
            end
         end
         fsgs_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_type_in = kind_ff;
            rsp_mat_in = rd_ok_ff ? rdata_a : fsgs_pkg::MAT_EMPTY;
            state_in = fsgs_pkg::ST_IDLE;
         end
         fsgs_pkg::ST_COPY: begin
            // The read word lands in the following cycle and is written to the same
            // address of the next-generation bank.
            cp_pend_in = 1'b1;
            cp_addr_in = idx_ff;
            idx_in = idx_ff + AW'(1);
            if (last_cell) begin
               idx_in = '0;
               x_in = '0;
               y_in = '0;
               state_in = fsgs_pkg::ST_CELL_RD;
            end
         end
         fsgs_pkg::ST_CELL_RD: begin
            state_in = fsgs_pkg::ST_CELL_EVAL;
         end
         fsgs_pkg::ST_CELL_EVAL: begin
            if (mat_active(rdata_a)) begin
               m_in = rdata_a;
               j_in = '0;
               state_in = fsgs_pkg::ST_RULE;
            end else begin
               advance = 1'b1;
            end
         end
         fsgs_pkg::ST_RULE: begin
            if (chk_ok && mov_ok) begin
               rd_addr_a = chk_addr;
               rd_addr_b = mov_addr;
               state_in = fsgs_pkg::ST_RULE_EVAL;
            end else if (j_ff == JW'(RULES_PER_MATERIAL - 1)) begin
               advance = 1'b1;
            end else begin
               j_in = j_ff + JW'(1);
            end
         end
         fsgs_pkg::ST_RULE_EVAL: begin
            if ((rdata_a == fsgs_pkg::MAT_EMPTY) && (rdata_b == fsgs_pkg::MAT_EMPTY)) begin
               scan_we = 1'b1;
               state_in = fsgs_pkg::ST_VACATE;
            end else if (j_ff == JW'(RULES_PER_MATERIAL - 1)) begin
               advance = 1'b1;
            end else begin
               j_in = j_ff + JW'(1);
               state_in = fsgs_pkg::ST_RULE;
            end
         end
         fsgs_pkg::ST_VACATE: begin
            scan_we = 1'b1;
            scan_waddr = idx_ff;
            scan_wdata = fsgs_pkg::MAT_EMPTY;
            advance = 1'b1;
         end
         default: begin
            state_in = fsgs_pkg::ST_IDLE;
         end
      endcase

      // Move the scan to the next cell and start its read, or finish the step.
      if (advance) begin
         if (last_cell) begin
            sel_in = !sel_ff;
            rsp_valid_in = 1'b1;
            rsp_type_in = kind_ff;
            rsp_mat_in = fsgs_pkg::MAT_EMPTY;
            state_in = fsgs_pkg::ST_IDLE;
         end else begin
            idx_in = idx_ff + AW'(1);
            rd_addr_a = idx_ff + AW'(1);
            if (x_ff == XW'(GRID_WIDTH - 1)) begin
               x_in = '0;
               y_in = y_ff + YW'(1);
            end else begin
               x_in = x_ff + XW'(1);
            end
            state_in = fsgs_pkg::ST_CELL_EVAL;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < fsgs_pkg::RULE_REG_COUNT; i++) begin
         rules_in[i] = rules_ff[i];
      end
      if (csr_we) begin
         case (csr_index)
            fsgs_pkg::CSR_RULES_WALL:  rules_in[0] = csr_wdata;
            fsgs_pkg::CSR_RULES_SAND:  rules_in[1] = csr_wdata;
            fsgs_pkg::CSR_RULES_SPARE: rules_in[2] = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Next-generation write port: copy sweep and scan never overlap.
   assign nxt_we = cp_pend_ff || scan_we;
   assign nxt_waddr = cp_pend_ff ? cp_addr_ff : scan_waddr;
   assign nxt_wdata = cp_pend_ff ? rdata_a : scan_wdata;

   assign b0_we = sel_ff ? nxt_we : cur_we;
   assign b0_waddr = sel_ff ? nxt_waddr : cur_waddr;
   assign b0_wdata = sel_ff ? nxt_wdata : cur_wdata;
   assign b1_we = sel_ff ? cur_we : nxt_we;
   assign b1_waddr = sel_ff ? cur_waddr : nxt_waddr;
   assign b1_wdata = sel_ff ? cur_wdata : nxt_wdata;

   assign rdata_a = sel_ff ? b1_rdata_a : b0_rdata_a;
   assign rdata_b = sel_ff ? b1_rdata_b : b0_rdata_b;

   fsgs_bank #(.DEPTH(CELLS)) u_bank0 (
      .clock   (clock),
      .we      (b0_we),
      .waddr   (b0_waddr),
      .wdata   (b0_wdata),
      .raddr_a (rd_addr_a),
      .raddr_b (rd_addr_b),
      .rdata_a (b0_rdata_a),
      .rdata_b (b0_rdata_b)
   );

   fsgs_bank #(.DEPTH(CELLS)) u_bank1 (
      .clock   (clock),
      .we      (b1_we),
      .waddr   (b1_waddr),
      .wdata   (b1_wdata),
      .raddr_a (rd_addr_a),
      .raddr_b (rd_addr_b),
      .rdata_a (b1_rdata_a),
      .rdata_b (b1_rdata_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsgs_pkg::ST_CLEAR;
         idx_ff <= '0;
         sel_ff <= 1'b0;
         cp_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rules_ff[0] <= '0;
         rules_ff[1] <= fsgs_pkg::SAND_RULES_RESET;
         rules_ff[2] <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         sel_ff <= sel_in;
         cp_pend_ff <= cp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < fsgs_pkg::RULE_REG_COUNT; i++) begin
            rules_ff[i] <= rules_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      j_ff <= j_in;
      m_ff <= m_in;
      kind_ff <= kind_in;
      rd_ok_ff <= rd_ok_in;
      cp_addr_ff <= cp_addr_in;
      rsp_type_ff <= rsp_type_in;
      rsp_mat_ff <= rsp_mat_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.resp_type = rsp_type_ff;
   assign rsp_ch.read_material = rsp_mat_ff;

   `FSGS_ASSERT_CLK(a_busy_no_rsp, clock, reset, (state_ff != fsgs_pkg::ST_IDLE) |-> !rsp_valid_ff, "result word pending while a request is still in progress")
   `FSGS_ASSERT_CLK(a_cur_write_ctx, clock, reset, cur_we |-> ((state_ff == fsgs_pkg::ST_CLEAR) || req_fire), "current grid written outside the clear sweep or a cell write")
   `FSGS_ASSERT_CLK(a_scan_copy_apart, clock, reset, scan_we |-> !cp_pend_ff, "scan write collides with a copy write")
   `FSGS_ASSERT_CLK(a_swap_answers, clock, reset, !$stable(sel_ff) |-> (rsp_valid_ff && (rsp_type_ff == fsgs_pkg::REQ_STEP)), "bank swap without a step result")

endmodule
